// ----- sv/pstd_pkg.sv -----
// Shared package for the point-to-segment distance unit.
// Holds the default coordinate width, the region codes and the control struct.
// No dependencies.
`default_nettype none
package pstd_pkg;
   localparam int COORD_WIDTH_DEF = 32;

   localparam logic [1:0] REGION_START    = 2'd0;
   localparam logic [1:0] REGION_END      = 2'd1;
   localparam logic [1:0] REGION_INTERIOR = 2'd2;

   typedef struct packed {
      logic       valid;
      logic [1:0] region;
   } ctl_type;
endpackage
`default_nettype wire

// ----- sv/pstd_front.sv -----
// Front end of the distance pipeline: differences, products, sums and region choice.
// Depends on pstd_pkg.
`default_nettype none
module pstd_front #(
   parameter int COORD_WIDTH = pstd_pkg::COORD_WIDTH_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       adv,
   input  wire logic                       load_en,
   input  wire logic                       in_valid,
   input  wire logic [COORD_WIDTH-1:0]     point_x,
   input  wire logic [COORD_WIDTH-1:0]     point_y,
   input  wire logic [COORD_WIDTH-1:0]     seg_start_x,
   input  wire logic [COORD_WIDTH-1:0]     seg_start_y,
   input  wire logic [COORD_WIDTH-1:0]     seg_end_x,
   input  wire logic [COORD_WIDTH-1:0]     seg_end_y,
   output logic                            first_valid,
   output pstd_pkg::ctl_type               ctl_o,
   output logic [2*COORD_WIDTH+1:0]        d_o,
   output logic [2*COORD_WIDTH+1:0]        m_o,
   output logic [2*COORD_WIDTH+1:0]        w_o
);
   import pstd_pkg::*;

   localparam int DW = COORD_WIDTH + 1;
   localparam int VW = 2 * COORD_WIDTH + 2;

   // Stage 1: coordinate differences.
   logic          s1_valid_ff;
   logic [DW-1:0] dx1_ff, dy1_ff, dx2_ff, dy2_ff, dx3_ff, dy3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (load_en) begin
         s1_valid_ff <= in_valid;
      end
      if (load_en) begin
         dx1_ff <= {seg_end_x[COORD_WIDTH-1], seg_end_x} - {seg_start_x[COORD_WIDTH-1], seg_start_x};
         dy1_ff <= {seg_end_y[COORD_WIDTH-1], seg_end_y} - {seg_start_y[COORD_WIDTH-1], seg_start_y};
         dx2_ff <= {point_x[COORD_WIDTH-1], point_x} - {seg_start_x[COORD_WIDTH-1], seg_start_x};
         dy2_ff <= {point_y[COORD_WIDTH-1], point_y} - {seg_start_y[COORD_WIDTH-1], seg_start_y};
         dx3_ff <= {point_x[COORD_WIDTH-1], point_x} - {seg_end_x[COORD_WIDTH-1], seg_end_x};
         dy3_ff <= {point_y[COORD_WIDTH-1], point_y} - {seg_end_y[COORD_WIDTH-1], seg_end_y};
      end
   end

   assign first_valid = s1_valid_ff;

   // Stage 2: signed products.
   logic                 s2_valid_ff;
   logic signed [VW-1:0] pdx_ff, pdy_ff, sx1_ff, sy1_ff, sx2_ff, sy2_ff, sx3_ff, sy3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (adv) begin
         pdx_ff <= $signed(dx1_ff) * $signed(dx2_ff);
         pdy_ff <= $signed(dy1_ff) * $signed(dy2_ff);
         sx1_ff <= $signed(dx1_ff) * $signed(dx1_ff);
         sy1_ff <= $signed(dy1_ff) * $signed(dy1_ff);
         sx2_ff <= $signed(dx2_ff) * $signed(dx2_ff);
         sy2_ff <= $signed(dy2_ff) * $signed(dy2_ff);
         sx3_ff <= $signed(dx3_ff) * $signed(dx3_ff);
         sy3_ff <= $signed(dy3_ff) * $signed(dy3_ff);
      end
   end

   // Stage 3: dot product and squared lengths.
   logic          s3_valid_ff;
   logic [VW-1:0] dot_ff, len2_ff, w2_ff, e2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (adv) begin
         dot_ff  <= VW'(pdx_ff + pdy_ff);
         len2_ff <= VW'(sx1_ff + sy1_ff);
         w2_ff   <= VW'(sx2_ff + sy2_ff);
         e2_ff   <= VW'(sx3_ff + sy3_ff);
      end
   end

   // Stage 4: region choice. Outside the interior the divider sees a zero
   // dividend and a unit divisor, so it yields nothing to subtract.
   ctl_type       ctl_in, ctl_ff;
   logic [VW-1:0] d_in, m_in, w_in, d_ff, m_ff, w_ff;

   always_comb begin
      ctl_in.valid = s3_valid_ff;
      if (dot_ff == '0 || dot_ff[VW-1]) begin
         ctl_in.region = REGION_START;
         w_in          = w2_ff;
         d_in          = '0;
         m_in          = VW'(1);
      end else if (dot_ff >= len2_ff) begin
         ctl_in.region = REGION_END;
         w_in          = e2_ff;
         d_in          = '0;
         m_in          = VW'(1);
      end else begin
         ctl_in.region = REGION_INTERIOR;
         w_in          = w2_ff;
         d_in          = dot_ff;
         m_in          = len2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (adv) begin
         ctl_ff.valid <= ctl_in.valid;
      end
      if (adv) begin
         ctl_ff.region <= ctl_in.region;
         d_ff          <= d_in;
         m_ff          <= m_in;
         w_ff          <= w_in;
      end
   end

   assign ctl_o = ctl_ff;
   assign d_o   = d_ff;
   assign m_o   = m_ff;
   assign w_o   = w_ff;
endmodule
`default_nettype wire

// ----- sv/pstd_div_cell.sv -----
// One step of the pipelined ceil(d*d/m) divider: takes one dividend bit.
// Depends on pstd_pkg.
`default_nettype none
module pstd_div_cell #(
   parameter int COORD_WIDTH = pstd_pkg::COORD_WIDTH_DEF,
   parameter int BIT_POS     = 0
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       adv,
   input  wire pstd_pkg::ctl_type          ctl_i,
   input  wire logic [2*COORD_WIDTH+1:0]   d_i,
   input  wire logic [2*COORD_WIDTH+1:0]   m_i,
   input  wire logic [2*COORD_WIDTH+1:0]   w_i,
   input  wire logic [2*COORD_WIDTH+1:0]   q_i,
   input  wire logic [2*COORD_WIDTH+1:0]   r_i,
   output pstd_pkg::ctl_type               ctl_o,
   output logic [2*COORD_WIDTH+1:0]        d_o,
   output logic [2*COORD_WIDTH+1:0]        m_o,
   output logic [2*COORD_WIDTH+1:0]        w_o,
   output logic [2*COORD_WIDTH+1:0]        q_o,
   output logic [2*COORD_WIDTH+1:0]        r_o
);
   import pstd_pkg::*;

   localparam int VW = 2 * COORD_WIDTH + 2;

   ctl_type       ctl_ff;
   logic [VW-1:0] d_ff, m_ff, w_ff, q_ff, r_ff, q_in, r_in;
   logic [VW-1:0] r_dbl, q_dbl;

   // Remainder stays below m: double it, reduce, add d when the bit is set, reduce.
   always_comb begin
      r_dbl = {r_i[VW-2:0], 1'b0};
      q_dbl = {q_i[VW-2:0], 1'b0};
      if (r_dbl >= m_i) begin
         r_dbl = r_dbl - m_i;
         q_dbl = q_dbl + VW'(1);
      end
      r_in = r_dbl;
      q_in = q_dbl;
      if (d_i[BIT_POS]) begin
         r_in = r_dbl + d_i;
         if (r_in >= m_i) begin
            r_in = r_in - m_i;
            q_in = q_dbl + VW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (adv) begin
         ctl_ff.valid <= ctl_i.valid;
      end
      if (adv) begin
         ctl_ff.region <= ctl_i.region;
         d_ff          <= d_i;
         m_ff          <= m_i;
         w_ff          <= w_i;
         q_ff          <= q_in;
         r_ff          <= r_in;
      end
   end

   assign ctl_o = ctl_ff;
   assign d_o   = d_ff;
   assign m_o   = m_ff;
   assign w_o   = w_ff;
   assign q_o   = q_ff;
   assign r_o   = r_ff;
endmodule
`default_nettype wire

// ----- sv/pstd_sqrt_cell.sv -----
// One step of the pipelined integer square root: settles one root bit.
// Depends on pstd_pkg.
`default_nettype none
module pstd_sqrt_cell #(
   parameter int COORD_WIDTH = pstd_pkg::COORD_WIDTH_DEF,
   parameter int BIT_POS     = 0
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       adv,
   input  wire pstd_pkg::ctl_type          ctl_i,
   input  wire logic [2*COORD_WIDTH+1:0]   rem_i,
   input  wire logic [COORD_WIDTH:0]       root_i,
   output pstd_pkg::ctl_type               ctl_o,
   output logic [2*COORD_WIDTH+1:0]        rem_o,
   output logic [COORD_WIDTH:0]            root_o
);
   import pstd_pkg::*;

   localparam int VW = 2 * COORD_WIDTH + 2;
   localparam int RW = COORD_WIDTH + 1;

   ctl_type       ctl_ff;
   logic [VW-1:0] rem_ff, rem_in, trial;
   logic [RW-1:0] root_ff, root_in;

   // rem holds n - root^2; setting this bit costs 2*root*2^b + 2^(2b).
   always_comb begin
      trial   = (VW'(root_i) << (BIT_POS + 1)) | (VW'(1) << (2 * BIT_POS));
      rem_in  = rem_i;
      root_in = root_i;
      if (rem_i >= trial) begin
         rem_in  = rem_i - trial;
         root_in = root_i | (RW'(1) << BIT_POS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (adv) begin
         ctl_ff.valid <= ctl_i.valid;
      end
      if (adv) begin
         ctl_ff.region <= ctl_i.region;
         rem_ff        <= rem_in;
         root_ff       <= root_in;
      end
   end

   assign ctl_o  = ctl_ff;
   assign rem_o  = rem_ff;
   assign root_o = root_ff;
endmodule
`default_nettype wire

// ----- sv/point_to_segment_distance_unit.sv -----
// Input passes the front end, the divider cells, a rounding register and the root cells.
// Throughput: one transfer per cycle while no result is held; the cell chains set depth.
// The whole pipeline holds while a result waits; an empty first stage still takes input.
// Reset (synchronous, active high) clears every stage valid bit; data registers keep
// their contents.
// Top level of the point-to-segment distance unit. Depends on pstd_pkg, pstd_front,
// pstd_div_cell and pstd_sqrt_cell.
`default_nettype none
module point_to_segment_distance_unit #(
   parameter int COORD_WIDTH = pstd_pkg::COORD_WIDTH_DEF
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     req_tvalid,
   output logic                                          req_tready,
   // Fields from bit 0 up: point_x, point_y, seg_start_x, seg_start_y,
   // seg_end_x, seg_end_y, each COORD_WIDTH bits; zero pad to whole bytes.
   input  wire logic [((6*COORD_WIDTH+7)/8)*8-1:0]       req_tdata,
   output logic                                          rsp_tvalid,
   input  wire logic                                     rsp_tready,
   // Fields from bit 0 up: dist_res (COORD_WIDTH+1 bits); zero pad to whole bytes.
   output logic [((COORD_WIDTH+1+7)/8)*8-1:0]            rsp_tdata,
   // Fields from bit 0 up: region (2 bits).
   output logic [1:0]                                    rsp_tuser
);
   import pstd_pkg::*;

   localparam int CW   = COORD_WIDTH;
   localparam int VW   = 2 * CW + 2;
   localparam int RW   = CW + 1;
   localparam int RSPW = ((CW + 1 + 7) / 8) * 8;
   // The positive dot product is below 2^(2*CW+1), so that many dividend bits.
   localparam int NDIV = 2 * CW + 1;
   localparam int NSQ  = CW + 1;

   // The pipeline moves as a whole unless the result register is held.
   logic adv;
   logic first_valid;
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv || !first_valid;

   ctl_type       div_ctl [NDIV+1];
   logic [VW-1:0] div_d [NDIV+1];
   logic [VW-1:0] div_m [NDIV+1];
   logic [VW-1:0] div_w [NDIV+1];
   logic [VW-1:0] div_q [NDIV+1];
   logic [VW-1:0] div_r [NDIV+1];

   pstd_front #(.COORD_WIDTH(CW)) u_front (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .load_en     (req_tready),
      .in_valid    (req_tvalid),
      .point_x     (req_tdata[0*CW +: CW]),
      .point_y     (req_tdata[1*CW +: CW]),
      .seg_start_x (req_tdata[2*CW +: CW]),
      .seg_start_y (req_tdata[3*CW +: CW]),
      .seg_end_x   (req_tdata[4*CW +: CW]),
      .seg_end_y   (req_tdata[5*CW +: CW]),
      .first_valid (first_valid),
      .ctl_o       (div_ctl[0]),
      .d_o         (div_d[0]),
      .m_o         (div_m[0]),
      .w_o         (div_w[0])
   );

   assign div_q[0] = '0;
   assign div_r[0] = '0;

   // Divider chain: cell k consumes dividend bit NDIV-1-k, top bit first.
   for (genvar k = 0; k < NDIV; k++) begin : g_div
      pstd_div_cell #(.COORD_WIDTH(CW), .BIT_POS(NDIV - 1 - k)) u_div (
         .clock (clock),
         .reset (reset),
         .adv   (adv),
         .ctl_i (div_ctl[k]),
         .d_i   (div_d[k]),
         .m_i   (div_m[k]),
         .w_i   (div_w[k]),
         .q_i   (div_q[k]),
         .r_i   (div_r[k]),
         .ctl_o (div_ctl[k+1]),
         .d_o   (div_d[k+1]),
         .m_o   (div_m[k+1]),
         .w_o   (div_w[k+1]),
         .q_o   (div_q[k+1]),
         .r_o   (div_r[k+1])
      );
   end

   // Rounding the quotient up and taking it off w, the squared distance to the start or, past the end, to the end.
   ctl_type       sq_ctl [NSQ+1];
   logic [VW-1:0] sq_rem [NSQ+1];
   logic [RW-1:0] sq_root [NSQ+1];
   ctl_type       fix_ctl_ff;
   logic [VW-1:0] fix_d2_ff, fix_d2_in, quot_up;

   always_comb begin
      quot_up   = div_q[NDIV] + VW'(div_r[NDIV] != '0);
      fix_d2_in = div_w[NDIV] - quot_up;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fix_ctl_ff.valid <= 1'b0;
      end else if (adv) begin
         fix_ctl_ff.valid <= div_ctl[NDIV].valid;
      end
      if (adv) begin
         fix_ctl_ff.region <= div_ctl[NDIV].region;
         fix_d2_ff         <= fix_d2_in;
      end
   end

   assign sq_ctl[0]  = fix_ctl_ff;
   assign sq_rem[0]  = fix_d2_ff;
   assign sq_root[0] = '0;

   // Root chain: cell k settles root bit CW-k, top bit first.
   for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
      pstd_sqrt_cell #(.COORD_WIDTH(CW), .BIT_POS(NSQ - 1 - k)) u_sqrt (
         .clock  (clock),
         .reset  (reset),
         .adv    (adv),
         .ctl_i  (sq_ctl[k]),
         .rem_i  (sq_rem[k]),
         .root_i (sq_root[k]),
         .ctl_o  (sq_ctl[k+1]),
         .rem_o  (sq_rem[k+1]),
         .root_o (sq_root[k+1])
      );
   end

   // The last root cell is the output register.
   assign rsp_tvalid = sq_ctl[NSQ].valid;
   assign rsp_tuser  = sq_ctl[NSQ].region;
   assign rsp_tdata  = RSPW'(sq_root[NSQ]);
endmodule
`default_nettype wire

// ----- sv/pstd_checker.sv -----
// Port-level checks for the point-to-segment distance unit, bound to its top level.
// Depends on pstd_pkg and point_to_segment_distance_unit.
`default_nettype none
module pstd_checker #(
   parameter int COORD_WIDTH = pstd_pkg::COORD_WIDTH_DEF
) (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_tready,
   input wire logic                                rsp_tvalid,
   input wire logic                                rsp_tready,
   input wire logic [((COORD_WIDTH+1+7)/8)*8-1:0]  rsp_tdata,
   input wire logic [1:0]                          rsp_tuser
);
   import pstd_pkg::*;

   // Reset empties the pipeline, so no result shows in the next cycle.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // Input is always taken while the result side is free to move.
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid || rsp_tready) |-> req_tready)
      else $error("input refused while pipeline can advance");

   // Only the three defined region codes are ever reported.
   a_region_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == REGION_START || rsp_tuser == REGION_END ||
                      rsp_tuser == REGION_INTERIOR))
      else $error("undefined region code");

   // A held result keeps its value.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) &&
                                       $stable(rsp_tuser)))
      else $error("held result changed");
endmodule

bind point_to_segment_distance_unit pstd_checker #(.COORD_WIDTH(COORD_WIDTH)) u_pstd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

// ----- sim/point_to_segment_distance_unit_tb.sv -----
// Self-checking testbench for point_to_segment_distance_unit: directed table, then random queries.
// Depends on pstd_pkg and the unit RTL. Expected results come from an in-bench integer predictor.
`timescale 1ns / 100ps
`default_nettype none
module point_to_segment_distance_unit_tb;
   import pstd_pkg::*;

   localparam int CW        = 32;
   localparam int REQ_W     = ((6*CW+7)/8)*8;
   localparam int RSP_W     = ((CW+1+7)/8)*8;
   localparam int N_RANDOM  = 1530;
   localparam int STALL_CAP = 10000;

   typedef struct {
      logic [CW:0] dist_res;
      logic [1:0]  region;
   } dist_result_type;

   // One row of the directed table. When has_known is set the typed-in result is checked,
   // otherwise the predictor supplies it.
   typedef struct {
      logic signed [CW-1:0] px, py, sx, sy, ex, ey;
      bit                   has_known;
      logic [CW:0]          dist_res;
      logic [1:0]           region;
   } query_row_type;

   logic               clock;
   logic               reset;
   logic               req_tvalid;
   logic               req_tready;
   // Fields from bit 0 up: point_x, point_y, seg_start_x, seg_start_y, seg_end_x, seg_end_y.
   logic [REQ_W-1:0]   req_tdata;
   logic               rsp_tvalid;
   logic               rsp_tready;
   // Fields from bit 0 up: dist_res (CW+1 bits), zero pad.
   logic [RSP_W-1:0]   rsp_tdata;
   // Fields from bit 0 up: region.
   logic [1:0]         rsp_tuser;

   dist_result_type    pending_dist_q[$];
   int                 error_count = 0;
   int                 rsp_count = 0;
   bit                 send_idle_on = 1;

   point_to_segment_distance_unit #(.COORD_WIDTH(CW)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Exact integer nearest-point distance. Differences take CW+2 bits and every product
   // is formed at 136 bits, so nothing wraps. In the interior case the squared distance
   // |W|^2 - dot^2/len2 is floored by subtracting the ceiling of the quotient, which gives
   // the same integer square root as the exact value.
   function automatic dist_result_type seg_distance(input logic [REQ_W-1:0] d);
      logic signed [CW+1:0]  px, py, sx, sy, ex, ey;
      logic signed [CW+1:0]  dx1, dy1, dx2, dy2, dx3, dy3;
      logic signed [135:0]   dot, len2, w2, d2, quot;
      logic [135:0]          cand;
      logic [CW:0]           root;
      dist_result_type       r;
      px = $signed(d[0*CW +: CW]);
      py = $signed(d[1*CW +: CW]);
      sx = $signed(d[2*CW +: CW]);
      sy = $signed(d[3*CW +: CW]);
      ex = $signed(d[4*CW +: CW]);
      ey = $signed(d[5*CW +: CW]);
      dx1 = ex - sx;  dy1 = ey - sy;
      dx2 = px - sx;  dy2 = py - sy;
      dx3 = px - ex;  dy3 = py - ey;
      dot  = dx1 * dx2 + dy1 * dy2;
      len2 = dx1 * dx1 + dy1 * dy1;
      w2   = dx2 * dx2 + dy2 * dy2;
      if (dot <= 0) begin
         r.region = REGION_START;
         d2 = w2;
      end else if (dot >= len2) begin
         r.region = REGION_END;
         d2 = dx3 * dx3 + dy3 * dy3;
      end else begin
         r.region = REGION_INTERIOR;
         quot = (dot * dot + len2 - 1) / len2;
         d2 = w2 - quot;
      end
      root = '0;
      for (int b = CW; b >= 0; b--) begin
         cand = 136'(root | ((CW+1)'(1) << b));
         if (cand * cand <= 136'(d2)) root = root | ((CW+1)'(1) << b);
      end
      r.dist_res = root;
      return r;
   endfunction

   // Coordinate mix: full range, small values, extremes and small multiples of 2^16.
   function automatic logic [CW-1:0] pick_coord();
      logic [CW-1:0] v;
      case ($urandom_range(0, 3))
         0: v = $urandom;
         1: v = CW'($signed($urandom_range(0, 2**21)) - 2**20);
         2: case ($urandom_range(0, 4))
               0: v = {1'b1, {(CW-1){1'b0}}};
               1: v = {1'b0, {(CW-1){1'b1}}};
               2: v = '0;
               3: v = '1;
               default: v = CW'(1);
            endcase
         default: v = CW'($signed($urandom_range(0, 64)) - 32) <<< 16;
      endcase
      return v;
   endfunction

   // Builds a query shaped toward one region or special case, with random content.
   function automatic logic [REQ_W-1:0] random_query();
      logic [CW-1:0] px, py, sx, sy, ex, ey, ddx, ddy;
      sx = pick_coord();  sy = pick_coord();
      if ($urandom_range(0, 1)) begin
         ddx = pick_coord();  ddy = pick_coord();
      end else begin
         ddx = CW'($signed($urandom_range(0, 2**24)) - 2**23);
         ddy = CW'($signed($urandom_range(0, 2**24)) - 2**23);
      end
      ex = sx + ddx;  ey = sy + ddy;
      case ($urandom_range(0, 7))
         0: begin px = pick_coord(); py = pick_coord(); end
         // Perpendicular through the start point: dot product is zero.
         1: begin px = sx - ddy; py = sy + ddx; end
         // Perpendicular through the end point: projection lands exactly on the end.
         2: begin px = ex - ddy; py = ey + ddx; end
         // Zero-length segment.
         3: begin ex = sx; ey = sy; px = pick_coord(); py = pick_coord(); end
         // Near the middle of the segment, offset sideways.
         4: begin
            px = sx + (ddx >>> 1) + CW'($signed($urandom_range(0, 2**16)) - 2**15);
            py = sy + (ddy >>> 1) + CW'($signed($urandom_range(0, 2**16)) - 2**15);
         end
         5: begin px = sx; py = sy; end
         default: begin
            px = sx + ddx + ddx + CW'($urandom_range(0, 255));
            py = sy + ddy + ddy + CW'($urandom_range(0, 255));
         end
      endcase
      return {ey, ex, sy, sx, py, px};
   endfunction

   // Offers one query and records its expected distance once the transfer happens.
   task automatic send_query(input logic [REQ_W-1:0] d, input bit has_known,
                             input dist_result_type known);
      int gap;
      gap = send_idle_on ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
      pending_dist_q.push_back(has_known ? known : seg_distance(d));
   endtask

   localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
   localparam logic signed [CW-1:0] ONE  = 32'sh0001_0000;

   query_row_type directed_rows[] = '{
      // px, py, sx, sy, ex, ey, known, dist_res, region
      '{0, 0, 0, 0, 0, 0, 1, 0, REGION_START},
      // Zero-length segment, 3-4-5 triangle.
      '{3*ONE, 4*ONE, 0, 0, 0, 0, 1, 5*ONE, REGION_START},
      // Point on the end: projection exactly at the end.
      '{10*ONE, 0, 0, 0, 10*ONE, 0, 1, 0, REGION_END},
      // Interior projection straight above the midpoint.
      '{5*ONE, 7*ONE, 0, 0, 10*ONE, 0, 1, 7*ONE, REGION_INTERIOR},
      // Dot product zero with a real segment.
      '{0, 5*ONE, 0, 0, 10*ONE, 0, 1, 5*ONE, REGION_START},
      // Behind the start.
      '{-4*ONE, 3*ONE, 0, 0, 10*ONE, 0, 1, 5*ONE, REGION_START},
      // Past the end.
      '{13*ONE, -4*ONE, 0, 0, 10*ONE, 0, 1, 5*ONE, REGION_END},
      '{CMAX, CMAX, CMIN, CMIN, CMIN, CMIN, 0, 0, REGION_START},
      '{CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, 0, 0, REGION_START},
      '{CMAX, CMIN, CMIN, CMAX, CMAX, CMAX, 0, 0, REGION_START},
      '{CMIN, CMAX, CMIN, CMIN, CMAX, CMAX, 0, 0, REGION_START},
      '{CMAX, CMAX, CMIN, CMIN, CMAX, CMIN, 0, 0, REGION_START},
      '{0, 0, CMIN, CMAX, CMAX, CMIN, 0, 0, REGION_START},
      '{-1, -1, 1, 1, -1, 1, 0, 0, REGION_START},
      '{1, 0, 0, 0, 3, 1, 0, 0, REGION_START},
      '{CMAX, 0, CMIN, 0, CMAX, 0, 0, 0, REGION_START},
      '{CMIN, CMIN, 0, 0, CMIN, CMIN, 0, 0, REGION_START}
   };

   // Stimulus and end of run.
   initial begin
      dist_result_type known;
      query_row_type   row;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         known.dist_res = row.dist_res;
         known.region   = row.region;
         send_query({REQ_W'(0) | {row.ey, row.ex, row.sy, row.sx, row.py, row.px}},
                    row.has_known, known);
      end
      for (int n = 0; n < N_RANDOM; n++) begin
         // Every 128 queries, choose at random whether the sender inserts gaps.
         if (n % 128 == 0) send_idle_on = $urandom_range(0, 2) != 0;
         // Once in the run the sender stops until every outstanding result is back.
         if (n == 1000) begin
            req_tvalid <= 1'b0;
            while (pending_dist_q.size() != 0) @(posedge clock);
         end
         send_query(random_query(), 1'b0, known);
      end
      req_tvalid <= 1'b0;
      while (pending_dist_q.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Result side: random ready stalls, plus one long hold-off that backs the pipeline up
   // into the input even when the sender inserts its longest gaps.
   initial begin
      dist_result_type want;
      int              stall;
      rsp_tready = 1'b0;
      @(negedge reset);
      @(posedge clock);
      forever begin
         if (rsp_count == 300) begin
            rsp_tready <= 1'b0;
            repeat (1500) @(posedge clock);
         end else begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         rsp_count++;
         if (pending_dist_q.size() == 0) begin
            $error("unexpected transfer: dist_res %0d region %0d",
                   rsp_tdata[CW:0], rsp_tuser);
            error_count++;
         end else begin
            want = pending_dist_q.pop_front();
            if (rsp_tdata[CW:0] !== want.dist_res) begin
               $error("dist_res: expected %0d, actual %0d", want.dist_res, rsp_tdata[CW:0]);
               error_count++;
            end
            if (rsp_tuser !== want.region) begin
               $error("region: expected %0d, actual %0d", want.region, rsp_tuser);
               error_count++;
            end
         end
      end
   end

   // Watchdog: counts cycles in which no transfer happens on either side.
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
         if (quiet >= STALL_CAP) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end
endmodule
`default_nettype wire
